// ===== design/cbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared widths, fixed-point constants and coefficient bundles for the
// cubic-bezier easing evaluator.
// ----------------------------------------------------------------------------
package cbe_pkg;

    localparam int WORK_BITS = 30;   // fractional bits of the Bernstein weights
    localparam int FRAC_BITS = 16;   // fractional bits of coordinates
    localparam int T_W       = 17;   // time input width
    localparam int CX_W      = 17;   // control x width
    localparam int CY_W      = 19;   // control y / output width
    localparam int CX3_W     = 19;   // width of 3 * control x
    localparam int CY3_W     = 21;   // width of 3 * control y (signed)
    localparam int IDX_W     = 2;    // config register index width

    // config register indexes
    localparam logic [IDX_W-1:0] REG_X1 = 2'd0;
    localparam logic [IDX_W-1:0] REG_Y1 = 2'd1;
    localparam logic [IDX_W-1:0] REG_X2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_Y2 = 2'd3;

    // output saturation limits, Q2.16
    localparam logic signed [24:0] OUT_MIN = -25'sd131072;
    localparam logic signed [24:0] OUT_MAX = 25'sd196608;

    // control x values pre-scaled by 3 (the Bernstein factor)
    typedef struct packed {
        logic [CX3_W-1:0] x1_3;
        logic [CX3_W-1:0] x2_3;
    } t_xcoef;

    // control y values pre-scaled by 3, two's complement
    typedef struct packed {
        logic [CY3_W-1:0] y1_3;
        logic [CY3_W-1:0] y2_3;
    } t_ycoef;

endpackage

// ===== design/cbe_weights.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_weights
// Three-stage pipeline producing the Bernstein products of u in Q.30:
// w3 = a^3, p2 = a^2 b, p1 = b^2 a, each truncated after every multiply.
// ----------------------------------------------------------------------------
module cbe_weights
    import cbe_pkg::*;
#(
    parameter int ITERATIONS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ITERATIONS-1:0] i_u,
    output logic [29:0]           o_w3,
    output logic [30:0]           o_p2,
    output logic [30:0]           o_p1
);

    logic [WORK_BITS-1:0] w_a;
    logic [WORK_BITS:0]   w_b;
    logic [59:0]          w_aa;
    logic [61:0]          w_bb;
    logic [59:0]          w_aaa;
    logic [60:0]          w_aab;
    logic [60:0]          w_bba;

    logic [WORK_BITS-1:0] r_a;
    logic [WORK_BITS:0]   r_b;
    logic [WORK_BITS-1:0] r_a_d;
    logic [WORK_BITS:0]   r_b_d;
    logic [29:0]          r_a2;
    logic [30:0]          r_b2;
    logic [29:0]          r_w3;
    logic [30:0]          r_p2;
    logic [30:0]          r_p1;

    generate
        if (ITERATIONS >= WORK_BITS) begin : g_trunc
            assign w_a = i_u[ITERATIONS-1 -: WORK_BITS];
        end else begin : g_extend
            assign w_a = {i_u, {(WORK_BITS-ITERATIONS){1'b0}}};
        end
    endgenerate

    assign w_b   = {1'b1, {WORK_BITS{1'b0}}} - {1'b0, w_a};
    assign w_aa  = r_a * r_a;
    assign w_bb  = r_b * r_b;
    assign w_aaa = r_a2 * r_a_d;
    assign w_aab = r_a2 * r_b_d;
    assign w_bba = r_b2 * r_a_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= w_a;
            r_b   <= w_b;
            r_a_d <= r_a;
            r_b_d <= r_b;
            r_a2  <= w_aa[59:30];
            r_b2  <= w_bb[60:30];
            r_w3  <= w_aaa[59:30];
            r_p2  <= w_aab[60:30];
            r_p1  <= w_bba[60:30];
        end
    end

    assign o_w3 = r_w3;
    assign o_p2 = r_p2;
    assign o_p1 = r_p1;

endmodule

// ===== design/cbe_bisect_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_bisect_step
// One bisection halving: evaluates x at the midpoint of the current interval
// and keeps the upper or lower half. Five register stages.
// ----------------------------------------------------------------------------
module cbe_bisect_step
    import cbe_pkg::*;
#(
    parameter int ITERATIONS = 24,
    parameter int STEP_IDX   = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [T_W-1:0]        i_time,
    input  logic [ITERATIONS-1:0] i_lo,
    input  t_xcoef                i_coef,
    output logic                  o_valid,
    output logic [T_W-1:0]        o_time,
    output logic [ITERATIONS-1:0] o_lo,
    output logic [ITERATIONS-1:0] o_u
);

    // half-width of the interval at this step
    localparam logic [ITERATIONS-1:0] HALF_BIT =
        {{(ITERATIONS-1){1'b0}}, 1'b1} << (ITERATIONS-1-STEP_IDX);

    logic [ITERATIONS-1:0] w_u;
    logic [29:0]           w_w3;
    logic [30:0]           w_p2;
    logic [30:0]           w_p1;
    logic [51:0]           w_x;
    logic [51:0]           w_target;
    logic                  w_below;

    logic                  r_vld  [0:3];
    logic [T_W-1:0]        r_time [0:3];
    logic [ITERATIONS-1:0] r_u    [0:3];
    logic [49:0]           r_m1;
    logic [49:0]           r_m2;
    logic [45:0]           r_w3s;
    logic                  r_out_vld;
    logic [T_W-1:0]        r_out_time;
    logic [ITERATIONS-1:0] r_out_lo;
    logic [ITERATIONS-1:0] r_out_u;

    assign w_u = i_lo | HALF_BIT;

    cbe_weights #(
        .ITERATIONS(ITERATIONS)
    ) u_weights (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_u   (w_u),
        .o_w3  (w_w3),
        .o_p2  (w_p2),
        .o_p1  (w_p1)
    );

    assign w_x      = 52'(r_m1) + 52'(r_m2) + 52'(r_w3s);
    assign w_target = 52'({r_time[3], {WORK_BITS{1'b0}}});
    assign w_below  = w_x < w_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0]  <= 1'b0;
            r_vld[1]  <= 1'b0;
            r_vld[2]  <= 1'b0;
            r_vld[3]  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld[0]  <= i_valid;
            r_vld[1]  <= r_vld[0];
            r_vld[2]  <= r_vld[1];
            r_vld[3]  <= r_vld[2];
            r_out_vld <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_time[0]  <= i_time;
            r_u[0]     <= w_u;
            r_time[1]  <= r_time[0];
            r_u[1]     <= r_u[0];
            r_time[2]  <= r_time[1];
            r_u[2]     <= r_u[1];
            r_time[3]  <= r_time[2];
            r_u[3]     <= r_u[2];
            r_m1       <= 50'(w_p1) * 50'(i_coef.x1_3);
            r_m2       <= 50'(w_p2) * 50'(i_coef.x2_3);
            r_w3s      <= {w_w3, {FRAC_BITS{1'b0}}};
            r_out_time <= r_time[3];
            r_out_u    <= r_u[3];
            r_out_lo   <= w_below ? r_u[3] : (r_u[3] & ~HALF_BIT);
        end
    end

    assign o_valid = r_out_vld;
    assign o_time  = r_out_time;
    assign o_lo    = r_out_lo;
    assign o_u     = r_out_u;

endmodule

// ===== design/cbe_y_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbe_y_eval
// Evaluates y at the solved parameter, rounds to Q2.16 (halves up) and
// saturates. Six register stages.
// ----------------------------------------------------------------------------
module cbe_y_eval
    import cbe_pkg::*;
#(
    parameter int ITERATIONS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [ITERATIONS-1:0] i_u,
    input  t_ycoef                i_coef,
    output logic                  o_valid,
    output logic [CY_W-1:0]       o_eased_value
);

    logic [29:0]        w_w3;
    logic [30:0]        w_p2;
    logic [30:0]        w_p1;
    logic signed [54:0] w_ysum;
    logic signed [24:0] w_y;
    logic [CY_W-1:0]    w_sat;

    logic               r_vld [0:4];
    logic signed [52:0] r_m1;
    logic signed [52:0] r_m2;
    logic [45:0]        r_w3s;
    logic signed [54:0] r_ysum;
    logic               r_out_vld;
    logic [CY_W-1:0]    r_out;

    cbe_weights #(
        .ITERATIONS(ITERATIONS)
    ) u_weights (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_u   (i_u),
        .o_w3  (w_w3),
        .o_p2  (w_p2),
        .o_p1  (w_p1)
    );

    // bias of one half LSB gives round-half-up with the arithmetic shift
    assign w_ysum = 55'(r_m1) + 55'(r_m2) + $signed({9'd0, r_w3s})
                  + $signed(55'(1) <<< (WORK_BITS-1));
    assign w_y    = $signed(r_ysum[54:30]);

    always_comb begin
        if (w_y < OUT_MIN) begin
            w_sat = OUT_MIN[CY_W-1:0];
        end else if (w_y > OUT_MAX) begin
            w_sat = OUT_MAX[CY_W-1:0];
        end else begin
            w_sat = w_y[CY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0]  <= 1'b0;
            r_vld[1]  <= 1'b0;
            r_vld[2]  <= 1'b0;
            r_vld[3]  <= 1'b0;
            r_vld[4]  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld[0]  <= i_valid;
            r_vld[1]  <= r_vld[0];
            r_vld[2]  <= r_vld[1];
            r_vld[3]  <= r_vld[2];
            r_vld[4]  <= r_vld[3];
            r_out_vld <= r_vld[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1   <= $signed({1'b0, w_p1}) * $signed(i_coef.y1_3);
            r_m2   <= $signed({1'b0, w_p2}) * $signed(i_coef.y2_3);
            r_w3s  <= {w_w3, {FRAC_BITS{1'b0}}};
            r_ysum <= w_ysum;
            r_out  <= w_sat;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_eased_value = r_out;

endmodule

// ===== design/cubic_bezier_ease_eval.sv =====
`timescale 1ns / 1ps
// Accepts one item per cycle unless the output is stalled; each bisection
// halving is its own five-stage section, followed by a six-stage y evaluator.
// A stalled output freezes the whole pipeline; no item is dropped.
// Reset (synchronous, active low) clears all valid bits and loads the
// default control points.
// ----------------------------------------------------------------------------
// cubic_bezier_ease_eval
// CSS-style cubic-bezier easing: solves x(u)=t by bisection, returns y(u).
// ----------------------------------------------------------------------------
module cubic_bezier_ease_eval
    import cbe_pkg::*;
#(
    parameter int ITERATIONS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [T_W-1:0]   i_time_in,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CY_W-1:0]  o_eased_value,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CY_W-1:0]  i_cfg_data
);

    // control points held pre-multiplied by 3
    localparam logic [CX3_W-1:0] X1_3_RST = 19'd49152;
    localparam logic [CY3_W-1:0] Y1_3_RST = 21'd19662;
    localparam logic [CX3_W-1:0] X2_3_RST = 19'd49152;
    localparam logic [CY3_W-1:0] Y2_3_RST = 21'd196608;

    function automatic logic [CX3_W-1:0] f_triple_x(input logic [CX_W-1:0] v);
        return {v, 1'b0} + CX3_W'(v);
    endfunction

    function automatic logic [CY3_W-1:0] f_triple_y(input logic [CY_W-1:0] v);
        logic [CY3_W-1:0] ext;
        ext = {{(CY3_W-CY_W){v[CY_W-1]}}, v};
        return {ext[CY3_W-2:0], 1'b0} + ext;
    endfunction

    logic [CX3_W-1:0] r_x1_3;
    logic [CY3_W-1:0] r_y1_3;
    logic [CX3_W-1:0] r_x2_3;
    logic [CY3_W-1:0] r_y2_3;
    t_xcoef           w_xcoef;
    t_ycoef           w_ycoef;
    logic             w_en;

    logic                  w_vld  [0:ITERATIONS];
    logic [T_W-1:0]        w_time [0:ITERATIONS];
    logic [ITERATIONS-1:0] w_lo   [0:ITERATIONS];
    logic [ITERATIONS-1:0] w_u    [1:ITERATIONS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_3 <= X1_3_RST;
            r_y1_3 <= Y1_3_RST;
            r_x2_3 <= X2_3_RST;
            r_y2_3 <= Y2_3_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X1: begin
                    r_x1_3 <= f_triple_x(i_cfg_data[CX_W-1:0]);
                end
                REG_Y1: begin
                    r_y1_3 <= f_triple_y(i_cfg_data);
                end
                REG_X2: begin
                    r_x2_3 <= f_triple_x(i_cfg_data[CX_W-1:0]);
                end
                REG_Y2: begin
                    r_y2_3 <= f_triple_y(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    assign w_xcoef = '{x1_3: r_x1_3, x2_3: r_x2_3};
    assign w_ycoef = '{y1_3: r_y1_3, y2_3: r_y2_3};

    // whole pipeline advances unless a finished item is held at the output
    assign w_en    = !o_valid || !i_stall;
    assign o_stall = !w_en;

    assign w_vld[0]  = i_valid;
    assign w_time[0] = i_time_in;
    assign w_lo[0]   = '0;

    generate
        for (genvar k = 0; k < ITERATIONS; k++) begin : g_step
            cbe_bisect_step #(
                .ITERATIONS(ITERATIONS),
                .STEP_IDX  (k)
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_vld[k]),
                .i_time  (w_time[k]),
                .i_lo    (w_lo[k]),
                .i_coef  (w_xcoef),
                .o_valid (w_vld[k+1]),
                .o_time  (w_time[k+1]),
                .o_lo    (w_lo[k+1]),
                .o_u     (w_u[k+1])
            );
        end
    endgenerate

    // result uses the last midpoint, not the final interval bound
    cbe_y_eval #(
        .ITERATIONS(ITERATIONS)
    ) u_y_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_vld[ITERATIONS]),
        .i_u           (w_u[ITERATIONS]),
        .i_coef        (w_ycoef),
        .o_valid       (o_valid),
        .o_eased_value (o_eased_value)
    );

    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_we |=> $stable(r_x1_3) && $stable(r_x2_3)
                      && $stable(r_y1_3) && $stable(r_y2_3))
        else $error("control point changed without a write");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_eased_value) >= $signed(OUT_MIN[CY_W-1:0]))
                 && ($signed(o_eased_value) <= $signed(19'sd196608)))
        else $error("eased value outside saturation range");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_vld[1]) && $stable(w_vld[ITERATIONS]))
        else $error("pipeline moved while output stalled");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |-> !o_stall)
        else $error("input stalled while output drains");

endmodule
